/* hw/rtl/dme_pkg.sv */
// Shared types, constants and helper functions for the determinant
// matrix element block. No dependencies.
package dme_pkg;

   localparam int ORBITALS = 16;
   localparam int ORB_W    = $clog2(ORBITALS);
   localparam int CNT_W    = $clog2(ORBITALS + 1);
   localparam int ONE_AW   = 2 * ORB_W;
   localparam int TWO_AW   = 4 * ORB_W;

   // command codes
   localparam logic [1:0] CMD_WR_ONE = 2'd0;
   localparam logic [1:0] CMD_WR_TWO = 2'd1;
   localparam logic [1:0] CMD_EVAL   = 2'd2;

   // excitation level codes
   localparam logic [1:0] LVL_DIAG   = 2'd0;
   localparam logic [1:0] LVL_SINGLE = 2'd1;
   localparam logic [1:0] LVL_DOUBLE = 2'd2;
   localparam logic [1:0] LVL_NONE   = 2'd3;

   typedef logic [ORB_W-1:0]    orb_type;
   typedef logic [ORBITALS-1:0] occ_type;

   // classification of one bra/ket pair
   typedef struct packed {
      logic [1:0] level;
      orb_type    ex0;
      orb_type    ex1;
      orb_type    ho0;
      orb_type    ho1;
      logic       neg;
   } class_type;

   // negate with saturation of the most negative value
   function automatic logic signed [31:0] neg_sat_f(input logic signed [31:0] v);
      logic signed [31:0] r;
      if (v == 32'sh8000_0000) begin
         r = 32'sh7FFF_FFFF;
      end else begin
         r = -v;
      end
      return r;
   endfunction

   // parity of occupied orbitals in [cre,ann) if ann>cre, else (ann,cre)
   function automatic logic parity_f(input occ_type occ, input orb_type ann,
                                     input orb_type cre);
      logic p;
      p = 1'b0;
      for (int k = 0; k < ORBITALS; k++) begin
         if (ann > cre) begin
            if (k >= int'(cre) && k < int'(ann)) p = p ^ occ[k];
         end else begin
            if (k > int'(ann) && k < int'(cre)) p = p ^ occ[k];
         end
      end
      return p;
   endfunction

endpackage

/* hw/rtl/dme_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module dme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* hw/rtl/dme_classify.sv */
// Excitation classifier: finds particle/hole orbitals and the fermionic
// sign of a bra/ket pair. Depends on dme_pkg.
module dme_classify (
   input  dme_pkg::occ_type   bra,
   input  dme_pkg::occ_type   ket,
   output dme_pkg::class_type cls
);
   import dme_pkg::*;

   localparam occ_type ORB_ONE = occ_type'(1);

   occ_type            exc;
   occ_type            hol;
   occ_type            proxy;
   logic [CNT_W-1:0]   ne;
   logic [CNT_W-1:0]   nh;
   orb_type            ex0, ex1, ho0, ho1;
   logic               fe0, fe1, fh0, fh1;
   logic               par0;

   assign exc = bra & ~ket;
   assign hol = ket & ~bra;

   // counts and first two set positions of each mask
   always_comb begin
      ne = '0; nh = '0;
      ex0 = '0; ex1 = '0; ho0 = '0; ho1 = '0;
      fe0 = 1'b0; fe1 = 1'b0; fh0 = 1'b0; fh1 = 1'b0;
      for (int k = 0; k < ORBITALS; k++) begin
         ne = ne + CNT_W'(exc[k]);
         nh = nh + CNT_W'(hol[k]);
         if (exc[k] && fe0 && !fe1) begin
            ex1 = orb_type'(k); fe1 = 1'b1;
         end
         if (exc[k] && !fe0) begin
            ex0 = orb_type'(k); fe0 = 1'b1;
         end
         if (hol[k] && fh0 && !fh1) begin
            ho1 = orb_type'(k); fh1 = 1'b1;
         end
         if (hol[k] && !fh0) begin
            ho0 = orb_type'(k); fh0 = 1'b1;
         end
      end
   end

   assign proxy = (ket & ~(ORB_ONE << ho0)) | (ORB_ONE << ex0);
   assign par0  = parity_f(ket, ho0, ex0);

   always_comb begin
      cls.ex0 = ex0;
      cls.ex1 = ex1;
      cls.ho0 = ho0;
      cls.ho1 = ho1;
      cls.neg = 1'b0;
      if (ne != nh || nh > CNT_W'(2)) begin
         cls.level = LVL_NONE;
      end else if (nh == '0) begin
         cls.level = LVL_DIAG;
      end else if (nh == CNT_W'(1)) begin
         cls.level = LVL_SINGLE;
         cls.neg   = par0;
      end else begin
         cls.level = LVL_DOUBLE;
         cls.neg   = 1'b1 ^ par0 ^ parity_f(proxy, ho1, ex1);
      end
   end

endmodule

/* hw/rtl/determinant_matrix_element_top.sv */
// Top level of the determinant matrix element block: tables in two RAMs,
// command sequencer and result register. Depends on dme_pkg, dme_ram, dme_classify.
//
// After reset the block runs a clearing pass over the two-body RAM, clearing
// the one-body RAM alongside, and accepts no transaction until it ends. A
// two-body write stores four copies through the single write port. For an
// evaluate, the diagonal and single cases read one two-body entry per cycle
// from the RAM's single read port. A finished result waits in an output
// register, so the next transaction is accepted while it has not yet been
// taken.
module determinant_matrix_element_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [3:0]         req_idx_p,
   input  logic [3:0]         req_idx_q,
   input  logic [3:0]         req_idx_r,
   input  logic [3:0]         req_idx_s,
   input  logic signed [31:0] req_entry_value,
   input  logic [15:0]        req_bra_occupation,
   input  logic [15:0]        req_ket_occupation,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [47:0] rsp_element_value,
   output logic [1:0]         rsp_excitation_level
);
   import dme_pkg::*;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_WR2   = 4'd2;
   localparam logic [3:0] ST_CLASS = 4'd3;
   localparam logic [3:0] ST_DIAG  = 4'd4;
   localparam logic [3:0] ST_SNGL  = 4'd5;
   localparam logic [3:0] ST_DBL   = 4'd6;
   localparam logic [3:0] ST_LAST  = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   localparam orb_type ORB_LAST = orb_type'(ORBITALS - 1);

   logic [3:0]          state_ff, state_in;
   logic [TWO_AW-1:0]   clr_ff, clr_in;
   logic [1:0]          wcnt_ff, wcnt_in;
   orb_type             i_ff, i_in, j_ff, j_in;
   orb_type             p_ff, p_in, q_ff, q_in, r_ff, r_in, s_ff, s_in;
   logic signed [31:0]  val_ff, val_in;
   occ_type             bra_ff, bra_in, ket_ff, ket_in;
   class_type           cls_ff, cls_in;
   class_type           cls_now;
   logic                m_one_ff, m_one_in, m_two_ff, m_two_in, m_neg_ff, m_neg_in;
   logic signed [47:0]  acc_ff, acc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [47:0]  rsp_value_ff, rsp_value_in;
   logic [1:0]          rsp_level_ff, rsp_level_in;

   logic                req_fire;
   logic                idx_ok;
   orb_type             ip, iq, ir, is;
   logic signed [31:0]  wval, wneg;

   logic                one_we, two_we;
   logic [ONE_AW-1:0]   one_waddr, one_raddr;
   logic [TWO_AW-1:0]   two_waddr, two_raddr;
   logic [31:0]         one_wdata, two_wdata, one_rd, two_rd;
   logic signed [47:0]  one_term, two_ext, two_term;

   dme_ram #(.WIDTH(32), .DEPTH(1 << ONE_AW)) u_one (
      .clock(clock), .wr_en(one_we), .wr_addr(one_waddr), .wr_data(one_wdata),
      .rd_addr(one_raddr), .rd_data(one_rd)
   );

   dme_ram #(.WIDTH(32), .DEPTH(1 << TWO_AW)) u_two (
      .clock(clock), .wr_en(two_we), .wr_addr(two_waddr), .wr_data(two_wdata),
      .rd_addr(two_raddr), .rd_data(two_rd)
   );

   dme_classify u_cls (.bra(bra_ff), .ket(ket_ff), .cls(cls_now));

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign ip = orb_type'(req_idx_p);
   assign iq = orb_type'(req_idx_q);
   assign ir = orb_type'(req_idx_r);
   assign is = orb_type'(req_idx_s);

   // antisymmetrized copy values of a two-body write
   assign wval = (p_ff == q_ff || r_ff == s_ff) ? 32'sd0 : val_ff;
   assign wneg = neg_sat_f(wval);

   // accumulator terms from last cycle's reads
   assign one_term = m_one_ff ? {{16{one_rd[31]}}, one_rd} : 48'sd0;
   assign two_ext  = {{16{two_rd[31]}}, two_rd};
   assign two_term = m_two_ff ? (m_neg_ff ? -two_ext : two_ext) : 48'sd0;

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      wcnt_in  = wcnt_ff;
      i_in = i_ff; j_in = j_ff;
      p_in = p_ff; q_in = q_ff; r_in = r_ff; s_in = s_ff;
      val_in = val_ff;
      bra_in = bra_ff; ket_in = ket_ff;
      cls_in = cls_ff;
      m_one_in = 1'b0; m_two_in = 1'b0; m_neg_in = 1'b0;
      acc_in = acc_ff + one_term + two_term;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_level_in = rsp_level_ff;

      idx_ok = int'(req_idx_r) < ORBITALS && int'(req_idx_s) < ORBITALS &&
               int'(req_idx_p) < ORBITALS && int'(req_idx_q) < ORBITALS;

      one_we    = 1'b0;
      one_waddr = {ir, is};
      one_wdata = req_entry_value;
      two_we    = 1'b0;
      two_waddr = {p_ff, q_ff, r_ff, s_ff};
      two_wdata = wval;
      one_raddr = {i_ff, i_ff};
      two_raddr = {i_ff, j_ff, j_ff, i_ff};

      case (state_ff)
         ST_CLEAR: begin
            one_we    = 1'b1;
            one_waddr = clr_ff[ONE_AW-1:0];
            one_wdata = '0;
            two_we    = 1'b1;
            two_waddr = clr_ff;
            two_wdata = '0;
            clr_in    = clr_ff + TWO_AW'(1);
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               p_in = ip; q_in = iq; r_in = ir; s_in = is;
               val_in = req_entry_value;
               bra_in = occ_type'(req_bra_occupation);
               ket_in = occ_type'(req_ket_occupation);
               wcnt_in = '0;
               case (req_command)
                  CMD_WR_ONE: begin
                     one_we = int'(req_idx_r) < ORBITALS && int'(req_idx_s) < ORBITALS;
                  end
                  CMD_WR_TWO: begin
                     if (idx_ok) state_in = ST_WR2;
                  end
                  CMD_EVAL: begin
                     state_in = ST_CLASS;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_WR2: begin
            // four sign-permuted copies, one per cycle
            two_we = 1'b1;
            case (wcnt_ff)
               2'd0: begin
                  two_waddr = {p_ff, q_ff, r_ff, s_ff}; two_wdata = wval;
               end
               2'd1: begin
                  two_waddr = {p_ff, q_ff, s_ff, r_ff}; two_wdata = wneg;
               end
               2'd2: begin
                  two_waddr = {q_ff, p_ff, r_ff, s_ff}; two_wdata = wneg;
               end
               default: begin
                  two_waddr = {q_ff, p_ff, s_ff, r_ff}; two_wdata = wval;
               end
            endcase
            wcnt_in = wcnt_ff + 2'd1;
            if (wcnt_ff == 2'd3) state_in = ST_IDLE;
         end
         ST_CLASS: begin
            cls_in = cls_now;
            acc_in = '0;
            i_in   = '0;
            j_in   = '0;
            case (cls_now.level)
               LVL_DIAG:   state_in = ST_DIAG;
               LVL_SINGLE: state_in = ST_SNGL;
               LVL_DOUBLE: state_in = ST_DBL;
               default:    state_in = ST_DONE;
            endcase
         end
         ST_DIAG: begin
            // pairs i <= j of orbitals occupied in both
            two_raddr = {i_ff, j_ff, j_ff, i_ff};
            one_raddr = {i_ff, i_ff};
            m_two_in  = bra_ff[i_ff] && ket_ff[i_ff] && bra_ff[j_ff] && ket_ff[j_ff];
            m_one_in  = bra_ff[i_ff] && ket_ff[i_ff] && (i_ff == j_ff);
            if (j_ff == ORB_LAST) begin
               if (i_ff == ORB_LAST) begin
                  state_in = ST_LAST;
               end else begin
                  i_in = i_ff + orb_type'(1);
                  j_in = i_ff + orb_type'(1);
               end
            end else begin
               j_in = j_ff + orb_type'(1);
            end
         end
         ST_SNGL: begin
            // walk all orbitals i, summing two-body terms of those occupied in the bra, plus the one-body term once
            two_raddr = {i_ff, cls_ff.ho0, i_ff, cls_ff.ex0};
            one_raddr = {cls_ff.ho0, cls_ff.ex0};
            m_one_in  = (i_ff == '0);
            m_two_in  = bra_ff[i_ff];
            m_neg_in  = (i_ff > cls_ff.ho0 && i_ff > cls_ff.ex0) ||
                        (i_ff < cls_ff.ho0 && i_ff < cls_ff.ex0);
            i_in = i_ff + orb_type'(1);
            if (i_ff == ORB_LAST) state_in = ST_LAST;
         end
         ST_DBL: begin
            two_raddr = {cls_ff.ex1, cls_ff.ex0, cls_ff.ho1, cls_ff.ho0};
            m_two_in  = 1'b1;
            state_in  = ST_LAST;
         end
         ST_LAST: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = cls_ff.neg ? -acc_ff : acc_ff;
               rsp_level_in = cls_ff.level;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         wcnt_ff      <= '0;
         m_one_ff     <= 1'b0;
         m_two_ff     <= 1'b0;
         m_neg_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wcnt_ff      <= wcnt_in;
         m_one_ff     <= m_one_in;
         m_two_ff     <= m_two_in;
         m_neg_ff     <= m_neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      i_ff <= i_in; j_ff <= j_in;
      p_ff <= p_in; q_ff <= q_in; r_ff <= r_in; s_ff <= s_in;
      val_ff <= val_in;
      bra_ff <= bra_in; ket_ff <= ket_in;
      cls_ff <= cls_in;
      acc_ff <= acc_in;
      rsp_value_ff <= rsp_value_in;
      rsp_level_ff <= rsp_level_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_element_value    = rsp_value_ff;
   assign rsp_excitation_level = rsp_level_ff;

endmodule

/* bench/tb_top.sv */
// Testbench for determinant_matrix_element_top: directed and random table writes
// and matrix element evaluations, checked against a scoreboard predictor.
// Depends on dme_pkg and the block's RTL.
module tb_top;
   import dme_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 300000;
   localparam int RAND_ITEMS = 900;
   localparam int HOLD_CYCLES = 700;

   typedef struct {
      logic signed [47:0] value;
      logic [1:0]         level;
   } element_type;

   // scoreboard: table copies, predictor and queue of expected elements
   class dme_scoreboard;
      bit signed [31:0] one_tbl [256];
      bit signed [31:0] two_tbl [65536];
      element_type      element_q [$];
      int               errors;

      function new();
         errors = 0;
      endfunction

      function bit signed [31:0] neg_clip(bit signed [31:0] v);
         return (v == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -v;
      endfunction

      function longint two_rd(int p, int q, int r, int s);
         return longint'(two_tbl[p * 4096 + q * 256 + r * 16 + s]);
      endfunction

      // parity of occupied orbitals passed over by the hop
      function bit hop_parity(logic [15:0] occ, int ann, int cre);
         int lo, hi;
         bit par;
         par = 1'b0;
         if (ann > cre) begin
            lo = cre;
            hi = ann;
         end else begin
            lo = ann + 1;
            hi = cre;
         end
         for (int k = lo; k < hi; k++) par ^= occ[k];
         return par;
      endfunction

      task report(string what, logic [47:0] got, logic [47:0] exp);
         $display("mismatch %s: got %h expected %h", what, got, exp);
         errors++;
      endtask

      // note an accepted request transaction
      function void note_request(logic [1:0] cmd, logic [3:0] p, logic [3:0] q,
                                 logic [3:0] r, logic [3:0] s,
                                 logic signed [31:0] v, logic [15:0] bra,
                                 logic [15:0] ket);
         bit signed [31:0] w;
         logic [15:0] exc, hol, same, proxy;
         int ex [16], ho [16], sm [16];
         int ne, nh, ns;
         longint sum, twos, t;
         element_type e;
         bit par;
         case (cmd)
            CMD_WR_ONE: begin
               one_tbl[{r, s}] = v;
            end
            CMD_WR_TWO: begin
               w = (p == q || r == s) ? 32'sd0 : v;
               two_tbl[{p, q, r, s}] = w;
               two_tbl[{p, q, s, r}] = neg_clip(w);
               two_tbl[{q, p, r, s}] = neg_clip(w);
               two_tbl[{q, p, s, r}] = w;
            end
            CMD_EVAL: begin
               exc = bra & ~ket;
               hol = ket & ~bra;
               same = bra & ket;
               ne = 0;
               nh = 0;
               ns = 0;
               for (int i = 0; i < 16; i++) begin
                  if (exc[i]) begin
                     ex[ne] = i;
                     ne++;
                  end
                  if (hol[i]) begin
                     ho[nh] = i;
                     nh++;
                  end
                  if (same[i]) begin
                     sm[ns] = i;
                     ns++;
                  end
               end
               sum = 0;
               if (ne != nh || nh > 2) begin
                  e.level = LVL_NONE;
               end else if (nh == 0) begin
                  for (int i = 0; i < ns; i++) begin
                     sum += longint'(one_tbl[sm[i] * 17]);
                     for (int j = i; j < ns; j++)
                        sum += two_rd(sm[i], sm[j], sm[j], sm[i]);
                  end
                  e.level = LVL_DIAG;
               end else if (nh == 2) begin
                  proxy = ket;
                  proxy[ho[0]] = 1'b0;
                  proxy[ex[0]] = 1'b1;
                  par = 1'b1 ^ hop_parity(ket, ho[0], ex[0])
                        ^ hop_parity(proxy, ho[1], ex[1]);
                  sum = two_rd(ex[1], ex[0], ho[1], ho[0]);
                  if (par) sum = -sum;
                  e.level = LVL_DOUBLE;
               end else begin
                  twos = 0;
                  for (int k = 0; k < 16; k++) begin
                     if (bra[k]) begin
                        t = two_rd(k, ho[0], k, ex[0]);
                        if ((k > ho[0] && k > ex[0]) || (k < ho[0] && k < ex[0]))
                           twos -= t;
                        else
                           twos += t;
                     end
                  end
                  sum = longint'(one_tbl[ho[0] * 16 + ex[0]]) + twos;
                  if (hop_parity(ket, ho[0], ex[0])) sum = -sum;
                  e.level = LVL_SINGLE;
               end
               e.value = sum[47:0];
               element_q = {element_q, e};
            end
            default: begin
            end
         endcase
      endfunction

      // compare one accepted response transaction with the oldest expectation
      task check_result(logic signed [47:0] value, logic [1:0] level);
         element_type e;
         if (element_q.size() == 0) begin
            report("unexpected response", value, {46'd0, level});
         end else begin
            e = element_q.pop_front();
            if (level !== e.level) report("excitation_level", {46'd0, level},
                                          {46'd0, e.level});
            if (value !== e.value) report("element_value", value, e.value);
         end
      endtask
   endclass

   logic               clock, reset;
   logic               req_valid, req_ready;
   logic [1:0]         req_command;
   logic [3:0]         req_idx_p, req_idx_q, req_idx_r, req_idx_s;
   logic signed [31:0] req_entry_value;
   logic [15:0]        req_bra_occupation, req_ket_occupation;
   logic               rsp_valid, rsp_ready;
   logic signed [47:0] rsp_element_value;
   logic [1:0]         rsp_excitation_level;

   dme_scoreboard sb;
   int burst_left;
   int responses_seen = 0;
   int idle_cycles = 0;

   determinant_matrix_element_top dut (.*);

   always #6 clock = ~clock;

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response checking at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_element_value, rsp_excitation_level);
         responses_seen++;
      end
   end

   // receiver stall pattern, with one long hold-off
   initial begin : receiver
      int hold_left, mode, mode_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 0;
      mode = 0;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (!hold_done && responses_seen >= 40) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(8, 64);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else begin
            case (mode)
               0: rsp_ready = 1'b1;
               1: rsp_ready = 1'($urandom_range(0, 1));
               default: rsp_ready = ($urandom_range(0, 5) == 0);
            endcase
         end
      end
   end

   // drive one request transaction and wait for its acceptance
   task send_item(logic [1:0] cmd, logic [3:0] p, logic [3:0] q, logic [3:0] r,
                  logic [3:0] s, logic signed [31:0] v, logic [15:0] bra,
                  logic [15:0] ket);
      @(negedge clock);
      req_valid = 1'b1;
      req_command = cmd;
      req_idx_p = p;
      req_idx_q = q;
      req_idx_r = r;
      req_idx_s = s;
      req_entry_value = v;
      req_bra_occupation = bra;
      req_ket_occupation = ket;
      do @(posedge clock); while (!req_ready);
      sb.note_request(cmd, p, q, r, s, v, bra, ket);
      // bursts of random length with gaps between them
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 10)) @(negedge clock);
         burst_left = $urandom_range(0, 20);
      end
   endtask

   // pick a random orbital whose bit in mask equals want, or -1
   function int pick_orb(logic [15:0] mask, bit want);
      int start;
      start = $urandom_range(0, 15);
      for (int i = 0; i < 16; i++)
         if (mask[(start + i) % 16] == want) return (start + i) % 16;
      return -1;
   endfunction

   // evaluate request with a bra that is a chosen excitation of the ket, or a random bra for more than two hops
   task send_eval(int hops);
      logic [15:0] ket, bra;
      int h, e;
      ket = 16'($urandom());
      bra = ket;
      for (int n = 0; n < hops; n++) begin
         h = pick_orb(bra & ket, 1'b1);
         e = pick_orb(bra | ket, 1'b0);
         if (h >= 0 && e >= 0) begin
            bra[h] = 1'b0;
            bra[e] = 1'b1;
         end
      end
      if (hops > 2) bra = 16'($urandom());
      send_item(CMD_EVAL, 4'($urandom()), 4'($urandom()), 4'($urandom()),
                4'($urandom()), 32'($urandom()), bra, ket);
   endtask

   task send_random;
      logic [3:0] p, q, r, s;
      int kind;
      p = 4'($urandom());
      q = 4'($urandom());
      r = 4'($urandom());
      s = 4'($urandom());
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
         send_item(CMD_WR_ONE, p, q, r, s, 32'($urandom()), 16'($urandom()),
                   16'($urandom()));
      end else if (kind < 40) begin
         // favor entries that diagonal and single elements read
         case ($urandom_range(0, 2))
            0: send_item(CMD_WR_TWO, p, q, q, p, 32'($urandom()), 16'($urandom()),
                         16'($urandom()));
            1: send_item(CMD_WR_TWO, p, q, p, s, 32'($urandom()), 16'($urandom()),
                         16'($urandom()));
            default: send_item(CMD_WR_TWO, p, q, r, s, 32'($urandom()),
                               16'($urandom()), 16'($urandom()));
         endcase
      end else if (kind < 95) begin
         send_eval($urandom_range(0, 3));
      end else begin
         send_item(CMD_UNUSED, p, q, r, s, 32'($urandom()), 16'($urandom()),
                   16'($urandom()));
      end
   endtask

   initial begin : stimulus
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_WR_ONE;
      req_idx_p = '0;
      req_idx_q = '0;
      req_idx_r = '0;
      req_idx_s = '0;
      req_entry_value = '0;
      req_bra_occupation = '0;
      req_ket_occupation = '0;
      rsp_ready = 1'b0;
      burst_left = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, antisymmetry, saturation, every level
      send_item(CMD_EVAL, 4'd0, 4'd0, 4'd0, 4'd0, 32'sd0, 16'hFFFF, 16'hFFFF);
      send_item(CMD_WR_ONE, 4'd15, 4'd0, 4'd15, 4'd15, 32'sh7FFF_FFFF, 16'h0, 16'h0);
      send_item(CMD_WR_ONE, 4'd0, 4'd0, 4'd0, 4'd0, 32'sh8000_0000, 16'h0, 16'h0);
      send_item(CMD_WR_ONE, 4'd0, 4'd0, 4'd3, 4'd9, 32'sd65536, 16'h0, 16'h0);
      send_item(CMD_WR_TWO, 4'd3, 4'd0, 4'd0, 4'd3, 32'sh8000_0000, 16'h0, 16'h0);
      send_item(CMD_WR_TWO, 4'd15, 4'd14, 4'd14, 4'd15, 32'sh7FFF_FFFF, 16'h0, 16'h0);
      send_item(CMD_WR_TWO, 4'd5, 4'd5, 4'd1, 4'd2, 32'sd12345, 16'h0, 16'h0);
      send_item(CMD_WR_TWO, 4'd6, 4'd7, 4'd4, 4'd4, -32'sd777, 16'h0, 16'h0);
      send_item(CMD_WR_TWO, 4'd9, 4'd1, 4'd3, 4'd1, -32'sd90000, 16'h0, 16'h0);
      send_item(CMD_WR_TWO, 4'd12, 4'd10, 4'd3, 4'd2, 32'sd5000, 16'h0, 16'h0);
      send_item(CMD_EVAL, 4'd0, 4'd0, 4'd0, 4'd0, 32'sd0, 16'hFFFF, 16'hFFFF);
      send_item(CMD_EVAL, 4'd0, 4'd0, 4'd0, 4'd0, 32'sd0, 16'h0000, 16'h0000);
      send_item(CMD_EVAL, 4'd0, 4'd0, 4'd0, 4'd0, 32'sd0, 16'hC009, 16'hC009);
      send_item(CMD_EVAL, 4'd0, 4'd0, 4'd0, 4'd0, 32'sd0, 16'h0203, 16'h000B);
      send_item(CMD_EVAL, 4'd0, 4'd0, 4'd0, 4'd0, 32'sd0, 16'h1402, 16'h000E);
      send_item(CMD_EVAL, 4'd0, 4'd0, 4'd0, 4'd0, 32'sd0, 16'h000E, 16'h1402);
      send_item(CMD_EVAL, 4'd0, 4'd0, 4'd0, 4'd0, 32'sd0, 16'h0007, 16'h0038);
      send_item(CMD_EVAL, 4'd0, 4'd0, 4'd0, 4'd0, 32'sd0, 16'h0001, 16'h0000);
      send_item(CMD_EVAL, 4'd0, 4'd0, 4'd0, 4'd0, 32'sd0, 16'h0000, 16'hFFFF);
      send_item(CMD_UNUSED, 4'd15, 4'd15, 4'd15, 4'd15, 32'sh7FFF_FFFF,
                16'hFFFF, 16'hFFFF);
      send_item(CMD_EVAL, 4'd0, 4'd0, 4'd0, 4'd0, 32'sd0, 16'hFFFF, 16'hFFFF);

      // random part
      repeat (RAND_ITEMS) send_random();
      @(negedge clock);
      req_valid = 1'b0;

      // drain, then let a last write settle
      while (sb.element_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.element_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

/* sim.f */
hw/rtl/dme_pkg.sv
hw/rtl/dme_ram.sv
hw/rtl/dme_classify.sv
hw/rtl/determinant_matrix_element_top.sv
bench/tb_top.sv
